// ===== rtl/mopc_pkg.sv =====
`default_nettype none

package mopc_pkg;

    // Screen and font geometry.
    localparam int SCREEN_WIDTH  = 240;
    localparam int SCREEN_HEIGHT = 135;
    localparam int CHAR_WIDTH    = 8;
    localparam int CHAR_HEIGHT   = 16;
    localparam int STRIP_ROWS    = 16;

    localparam int STRIP_TOP = SCREEN_HEIGHT - STRIP_ROWS;
    localparam int STRIP_END = STRIP_TOP + CHAR_HEIGHT;
    localparam int NAME_FIT  = SCREEN_WIDTH / CHAR_WIDTH;

    // RGB565 palette.
    localparam logic [15:0] C_LAND   = 16'h2E05;
    localparam logic [15:0] C_OCEAN  = 16'h3B7F;
    localparam logic [15:0] C_YELLOW = 16'hFFE0;
    localparam logic [15:0] C_RED    = 16'hF800;
    localparam logic [15:0] C_WHITE  = 16'hFFFF;

    // Pulse limits.
    localparam logic [3:0] PULSE_MAX   = 4'd10;
    localparam logic [3:0] PULSE_MIN   = 4'd3;
    localparam logic [3:0] PULSE_RESET = 4'd3;

    // Configuration port.
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    typedef enum logic [2:0] {
        REG_STATION_COL = 3'd0,
        REG_STATION_ROW = 3'd1,
        REG_SAT_COL     = 3'd2,
        REG_SAT_ROW     = 3'd3,
        REG_SAT_VISIBLE = 3'd4,
        REG_NAME_CHARS  = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [7:0] station_col;
        logic [7:0] station_row;
        logic [7:0] sat_col;
        logic [7:0] sat_row;
        logic       sat_visible;
        logic [4:0] name_chars;
    } cfg_t;

    typedef struct packed {
        logic [7:0] col;
        logic [7:0] row;
        logic       land;
        logic       present;
        logic       gbit;
    } pix_t;

endpackage

`default_nettype wire

// ===== rtl/mopc_regs.sv =====
`default_nettype none

module mopc_regs (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [mopc_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [mopc_pkg::PDATA_W-1:0]  pwdata,
    output logic      [mopc_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready,
    output mopc_pkg::cfg_t                     cfg
);

    mopc_pkg::cfg_t cfg_reg;
    mopc_pkg::cfg_t cfg_next;
    logic [2:0]     idx;
    logic           wr_en;

    assign idx    = paddr[4:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                mopc_pkg::REG_STATION_COL: cfg_next.station_col = pwdata[7:0];
                mopc_pkg::REG_STATION_ROW: cfg_next.station_row = pwdata[7:0];
                mopc_pkg::REG_SAT_COL:     cfg_next.sat_col     = pwdata[7:0];
                mopc_pkg::REG_SAT_ROW:     cfg_next.sat_row     = pwdata[7:0];
                mopc_pkg::REG_SAT_VISIBLE: cfg_next.sat_visible = pwdata[0];
                mopc_pkg::REG_NAME_CHARS:  cfg_next.name_chars  = pwdata[4:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        prdata = '0;
        unique case (idx)
            mopc_pkg::REG_STATION_COL: prdata[7:0] = cfg_reg.station_col;
            mopc_pkg::REG_STATION_ROW: prdata[7:0] = cfg_reg.station_row;
            mopc_pkg::REG_SAT_COL:     prdata[7:0] = cfg_reg.sat_col;
            mopc_pkg::REG_SAT_ROW:     prdata[7:0] = cfg_reg.sat_row;
            mopc_pkg::REG_SAT_VISIBLE: prdata[0]   = cfg_reg.sat_visible;
            mopc_pkg::REG_NAME_CHARS:  prdata[4:0] = cfg_reg.name_chars;
            default:                   prdata      = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/mopc_pulse.sv =====
`default_nettype none

module mopc_pulse (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       advance,
    output logic      [3:0] radius
);

    logic [3:0] pulse_radius_reg;
    logic [3:0] pulse_radius_next;
    logic       pulse_shrinking_reg;
    logic       pulse_shrinking_next;
    logic [3:0] stepped;

    // The radius handed out is the one after this beat's step, if any.
    assign radius = pulse_radius_next;

    always_comb begin
        stepped = pulse_shrinking_reg ? pulse_radius_reg - 4'd1 : pulse_radius_reg + 4'd1;
        pulse_radius_next    = pulse_radius_reg;
        pulse_shrinking_next = pulse_shrinking_reg;
        if (advance) begin
            pulse_radius_next = stepped;
            if (stepped >= mopc_pkg::PULSE_MAX) begin
                pulse_shrinking_next = 1'b1;
            end else if (stepped <= mopc_pkg::PULSE_MIN) begin
                pulse_shrinking_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pulse_radius_reg    <= mopc_pkg::PULSE_RESET;
            pulse_shrinking_reg <= 1'b0;
        end else begin
            pulse_radius_reg    <= pulse_radius_next;
            pulse_shrinking_reg <= pulse_shrinking_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mopc_shade.sv =====
`default_nettype none

module mopc_shade (
    input  mopc_pkg::pix_t       pix,
    input  wire logic      [3:0] radius,
    input  mopc_pkg::cfg_t       cfg,
    output logic          [15:0] colour
);

    logic              stn_hit;
    logic              sat_hit_red;
    logic              sat_hit_white;
    logic              strip_hit;
    logic [8:0]        col9;
    logic [8:0]        row9;
    logic [8:0]        scol9;
    logic [8:0]        srow9;
    logic signed [8:0] dx;
    logic signed [8:0] dy;
    logic [8:0]        dx_mag;
    logic [8:0]        dy_mag;
    logic [4:0]        ro;
    logic [9:0]        dx_sq;
    logic [9:0]        dy_sq;
    logic [10:0]       d2;
    logic [9:0]        rf_sq;
    logic [9:0]        ro_sq;
    logic              in_box;
    logic [4:0]        char_idx;
    logic [4:0]        limit;

    assign col9  = {1'b0, pix.col};
    assign row9  = {1'b0, pix.row};
    assign scol9 = {1'b0, cfg.station_col};
    assign srow9 = {1'b0, cfg.station_row};

    // Station dot: 3x3 around the centre, centre column kept off the screen edges.
    assign stn_hit = (cfg.station_col >= 8'd1)
                  && (scol9 < 9'(mopc_pkg::SCREEN_WIDTH - 1))
                  && (row9 + 9'd1 >= srow9) && (row9 <= srow9 + 9'd1)
                  && (col9 + 9'd1 >= scol9) && (col9 <= scol9 + 9'd1);

    // Satellite disc: offsets, box test, then small squares.
    assign dx     = $signed(col9) - $signed({1'b0, cfg.sat_col});
    assign dy     = $signed(row9) - $signed({1'b0, cfg.sat_row});
    assign dx_mag = dx[8] ? 9'(-dx) : 9'(dx);
    assign dy_mag = dy[8] ? 9'(-dy) : 9'(dy);
    assign ro     = {1'b0, radius} + 5'd1;
    assign in_box = (dx_mag <= {4'b0, ro}) && (dy_mag <= {4'b0, ro});
    assign dx_sq  = dx_mag[4:0] * dx_mag[4:0];
    assign dy_sq  = dy_mag[4:0] * dy_mag[4:0];
    assign d2     = {1'b0, dx_sq} + {1'b0, dy_sq};
    assign rf_sq  = {6'b0, radius} * {6'b0, radius};
    assign ro_sq  = {5'b0, ro} * {5'b0, ro};

    assign sat_hit_red   = cfg.sat_visible && (col9 < 9'(mopc_pkg::SCREEN_WIDTH)) && in_box
                        && (d2 <= {1'b0, rf_sq});
    assign sat_hit_white = cfg.sat_visible && (col9 < 9'(mopc_pkg::SCREEN_WIDTH)) && in_box
                        && (d2 <= {1'b0, ro_sq});

    // Name strip along the bottom rows.
    assign char_idx  = 5'(pix.col / mopc_pkg::CHAR_WIDTH);
    assign limit     = (cfg.name_chars > 5'(mopc_pkg::NAME_FIT)) ? 5'(mopc_pkg::NAME_FIT)
                                                                 : cfg.name_chars;
    assign strip_hit = (row9 >= 9'(mopc_pkg::STRIP_TOP)) && (row9 < 9'(mopc_pkg::STRIP_END))
                    && (char_idx < limit) && pix.present;

    always_comb begin
        priority if (strip_hit) begin
            colour = pix.gbit ? mopc_pkg::C_WHITE : mopc_pkg::C_OCEAN;
        end else if (sat_hit_red) begin
            colour = mopc_pkg::C_RED;
        end else if (sat_hit_white) begin
            colour = mopc_pkg::C_WHITE;
        end else if (stn_hit) begin
            colour = mopc_pkg::C_YELLOW;
        end else begin
            colour = pix.land ? mopc_pkg::C_LAND : mopc_pkg::C_OCEAN;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/map_overlay_pixel_compositor.sv =====
// Channel   | Direction | Handshake          | Payload
// ----------+-----------+--------------------+-------------------------------------------
// s_        | in        | s_valid / s_ready  | pix_col, pix_row, map_land, glyph_present,
//           |           |                    | glyph_bit, frame_start
// m_        | out       | m_valid / m_ready  | pixel_colour
// APB       | in/out    | psel/penable/pready| paddr, pwdata, prdata (six registers)
//
// One pixel beat is accepted per clock cycle while the result side keeps up; each
// beat's colour is loaded into the result register once the result side is free
// and shown on m_ from then on (input register, then result register).
// The rate is set by the single colouring pass between those two registers.
// aresetn is synchronous and active low; it empties both stages, clears the
// configuration registers and sets the pulse to radius 3, growing.
// A stall on m_ready holds the result; the input register still takes one more beat if it is empty.
`default_nettype none

module map_overlay_pixel_compositor (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // Pixel input beats.
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [7:0]                    s_pix_col,
    input  wire logic [7:0]                    s_pix_row,
    input  wire logic                          s_map_land,
    input  wire logic                          s_glyph_present,
    input  wire logic                          s_glyph_bit,
    input  wire logic                          s_frame_start,
    // Colour output beats.
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [15:0]                   m_pixel_colour,
    // Configuration port.
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [mopc_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [mopc_pkg::PDATA_W-1:0]  pwdata,
    output logic      [mopc_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready
);

    mopc_pkg::cfg_t cfg;
    mopc_pkg::pix_t pix_in;
    mopc_pkg::pix_t pix_reg;
    logic [3:0]     radius_now;
    logic [3:0]     radius_reg;
    logic           in_valid_reg;
    logic           in_valid_next;
    logic           out_valid_reg;
    logic           out_valid_next;
    logic [15:0]    colour;
    logic [15:0]    colour_reg;
    logic           s_fire;
    logic           move;

    mopc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The pulse steps as the beat is accepted, so the radius captured alongside the
    // pixel already includes its own frame start.
    mopc_pulse u_pulse (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (s_fire && s_frame_start),
        .radius  (radius_now)
    );

    assign pix_in.col     = s_pix_col;
    assign pix_in.row     = s_pix_row;
    assign pix_in.land    = s_map_land;
    assign pix_in.present = s_glyph_present;
    assign pix_in.gbit    = s_glyph_bit;

    // The input stage moves on whenever the result register is free or being emptied.
    assign move    = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || move;
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (move) begin
            out_valid_next = in_valid_reg;
        end
        if (s_ready) begin
            in_valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            pix_reg    <= pix_in;
            radius_reg <= radius_now;
        end
        if (move && in_valid_reg) begin
            colour_reg <= colour;
        end
    end

    mopc_shade u_shade (
        .pix    (pix_reg),
        .radius (radius_reg),
        .cfg    (cfg),
        .colour (colour)
    );

    assign m_valid        = out_valid_reg;
    assign m_pixel_colour = colour_reg;

endmodule

`default_nettype wire

// ===== rtl/mopc_checker.sv =====
`default_nettype none

module mopc_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_ready,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic [15:0]                   m_pixel_colour,
    input wire logic                          pready
);

    // A result beat is always one of the five palette colours.
    a_palette: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_pixel_colour == mopc_pkg::C_LAND)
                 || (m_pixel_colour == mopc_pkg::C_OCEAN)
                 || (m_pixel_colour == mopc_pkg::C_YELLOW)
                 || (m_pixel_colour == mopc_pkg::C_RED)
                 || (m_pixel_colour == mopc_pkg::C_WHITE))
        else $error("result colour outside the palette");

    // With the result side empty the block must be able to take a beat.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled while the result register is empty");

    // Reset leaves no result on the output.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat present straight after reset");

    // A stalled result beat holds its colour.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_pixel_colour)))
        else $error("stalled result beat changed");

    // The configuration port never inserts wait states.
    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("configuration port stalled");

endmodule

bind map_overlay_pixel_compositor mopc_checker u_mopc_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_pixel_colour (m_pixel_colour),
    .pready         (pready)
);

`default_nettype wire
